>>> hw/rtl/bpa_pkg.sv
package bpa_pkg;

   localparam int PAGE_W      = 15;
   localparam int REL_W       = 13;
   localparam int COUNT_W     = 14;
   localparam int WORD_W      = 16;
   localparam int DADDR_W     = 16;
   localparam int WIDX_W      = 10;
   localparam int RECIP_W     = 14;
   localparam int RECIP_SHIFT = 17;
   localparam int Q12_W       = 10;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 14'h3fff;
   localparam logic [RECIP_W-1:0] RECIP_12  = 14'd10923;
   localparam logic [WORD_W-1:0]  ALL_USED  = 16'hffff;
   localparam logic [WORD_W-1:0]  TOP_BIT   = 16'h8000;

   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE  = 2'd1;
   localparam logic [1:0] MODE_LOAD  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_ENC_MUL,
      ST_ENC_OUT,
      ST_FREE_CHK,
      ST_LOAD_CHK
   } state_type;

endpackage

>>> hw/rtl/bpa_ram.sv
module bpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
)(
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hw/rtl/bitmap_page_allocator.sv
// Channel   Ports                                             Handshake
// request   start, busy, req_mode, req_disk_address,          start & !busy
//           req_word_index, req_word_value
// result    rsp_strobe, rsp_new_address, rsp_found,           rsp_strobe, one cycle
//           rsp_pages_left
// config    csr_write_enable, csr_write_data                  csr_write_enable
//
// After reset a clearing pass sets every bitmap word to all used, with busy high.
// Allocate: decode, scan the bitmap words in turn (single RAM read port), then encode on a hit;
// a full wrapped scan reads every word in range plus the start word again.
// Free and load: read, modify, write, then the result; a rejected request gets its result from decode.
// One request at a time; results cannot be stalled.
module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int PAGES_PER_DISK = 4872,
   parameter int BITMAP_WORDS   = 1024
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_mode,
   input  logic [DADDR_W-1:0]  req_disk_address,
   input  logic [WIDX_W-1:0]   req_word_index,
   input  logic [WORD_W-1:0]   req_word_value,
   output logic                rsp_strobe,
   output logic [DADDR_W-1:0]  rsp_new_address,
   output logic                rsp_found,
   output logic [COUNT_W-1:0]  rsp_pages_left,
   input  logic                csr_write_enable,
   input  logic                csr_write_data
);

   localparam int AW       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int PAGE_CAP = BITMAP_WORDS * 16;
   localparam int LIM_ONE  = (PAGES_PER_DISK < PAGE_CAP) ? PAGES_PER_DISK : PAGE_CAP;
   localparam int LIM_TWO  = (2 * PAGES_PER_DISK < PAGE_CAP) ? 2 * PAGES_PER_DISK : PAGE_CAP;
   localparam int MUL_W    = REL_W + RECIP_W;

   state_type state_ff, state_in;

   logic                dd_ff;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [1:0]          mode_ff, mode_in;
   logic [DADDR_W-1:0]  daddr_ff, daddr_in;
   logic [WIDX_W-1:0]   widx_ff, widx_in;
   logic [WORD_W-1:0]   wval_ff, wval_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [AW-1:0]       sw_ff, sw_in;
   logic [3:0]          so_ff, so_in;
   logic [AW-1:0]       iss_word_ff, iss_word_in;
   logic                iss_phase_ff, iss_phase_in;
   logic                iss_done_ff, iss_done_in;
   logic [AW-1:0]       tag_word_ff, tag_word_in;
   logic                tag_phase_ff, tag_phase_in;
   logic                tag_vld_ff, tag_vld_in;
   logic [REL_W-1:0]    rel_ff, rel_in;
   logic                disk_ff, disk_in;
   logic [MUL_W-1:0]    mul_ff, mul_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [DADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]  rsp_free_ff, rsp_free_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [WORD_W-1:0]   ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [WORD_W-1:0]   ram_rd_data;

   logic [PAGE_W-1:0]   lim, lim_m1;
   logic [AW-1:0]       last_word;
   logic [AW:0]         lim_words;
   logic [3:0]          lim_nib;
   logic [PAGE_W-1:0]   dec_page, start_page;
   logic                in_range, widx_ok;
   logic [WORD_W-1:0]   phase_mask, scan_mask, cand, bit_mask;
   logic                hit_any, tag_final, page_used;
   logic [3:0]          hit_idx;
   logic [PAGE_W-1:0]   hit_page;
   logic [4:0]          old_free, new_free, free_diff;
   logic [COUNT_W:0]    load_sum;
   logic [COUNT_W-1:0]  load_count;
   logic [REL_W-1:0]    rel_comb;
   logic                disk_comb;
   logic [Q12_W-1:0]    q12;
   logic [3:0]          sector;
   logic [DADDR_W-1:0]  new_addr;

   function automatic logic [WORD_W-1:0] valid_mask(input logic [AW-1:0] w,
                                                    input logic [AW:0] lw,
                                                    input logic [3:0] ln);
      logic [WORD_W-1:0] m;
      if ({1'b0, w} < lw) begin
         m = ALL_USED;
      end else if ({1'b0, w} == lw) begin
         m = ~(ALL_USED >> ln);
      end else begin
         m = '0;
      end
      return m;
   endfunction

   function automatic logic [4:0] ones(input logic [WORD_W-1:0] v);
      logic [4:0] n;
      n = '0;
      for (int i = 0; i < WORD_W; i++) begin
         n = n + 5'(v[i]);
      end
      return n;
   endfunction

   bpa_ram #(
      .WIDTH(WORD_W),
      .DEPTH(BITMAP_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_data)
   );

   // limits, decode, scan unit, free and load checks, encode
   always_comb begin
      lim       = dd_ff ? PAGE_W'(LIM_TWO) : PAGE_W'(LIM_ONE);
      lim_m1    = lim - PAGE_W'(1);
      last_word = lim_m1[AW+3:4];
      lim_words = lim[AW+4:4];
      lim_nib   = lim[3:0];

      dec_page = PAGE_W'({daddr_ff[11:3], 4'b0}) + PAGE_W'({daddr_ff[11:3], 3'b0})
               + (daddr_ff[2] ? PAGE_W'(12) : '0) + PAGE_W'(daddr_ff[15:12])
               + (daddr_ff[1] ? PAGE_W'(PAGES_PER_DISK) : '0);
      in_range   = dec_page < lim;
      start_page = in_range ? dec_page : '0;
      widx_ok    = {1'b0, widx_ff} < (WIDX_W+1)'(BITMAP_WORDS);

      tag_final = tag_phase_ff && (tag_word_ff == sw_ff);
      if (tag_word_ff == sw_ff) begin
         phase_mask = tag_phase_ff ? ~(ALL_USED >> so_ff) : (ALL_USED >> so_ff);
      end else begin
         phase_mask = ALL_USED;
      end
      scan_mask = phase_mask & valid_mask(tag_word_ff, lim_words, lim_nib);
      cand      = ~ram_rd_data & scan_mask;
      hit_any   = |cand;
      hit_idx   = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (cand[i]) begin
            hit_idx = 4'(15 - i);
         end
      end
      hit_page = PAGE_W'({tag_word_ff, hit_idx});

      bit_mask  = TOP_BIT >> page_ff[3:0];
      page_used = |(ram_rd_data & bit_mask);

      old_free = ones(~ram_rd_data & valid_mask(widx_ff[AW-1:0], lim_words, lim_nib));
      new_free = ones(~wval_ff & valid_mask(widx_ff[AW-1:0], lim_words, lim_nib));
      if (new_free >= old_free) begin
         free_diff  = new_free - old_free;
         load_sum   = {1'b0, count_ff} + (COUNT_W+1)'(free_diff);
         load_count = (load_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : load_sum[COUNT_W-1:0];
      end else begin
         free_diff  = old_free - new_free;
         load_sum   = '0;
         load_count = (count_ff > COUNT_W'(free_diff)) ?
                      count_ff - COUNT_W'(free_diff) : '0;
      end

      if (page_ff >= PAGE_W'(PAGES_PER_DISK)) begin
         rel_comb  = REL_W'(page_ff - PAGE_W'(PAGES_PER_DISK));
         disk_comb = 1'b1;
      end else begin
         rel_comb  = REL_W'(page_ff);
         disk_comb = 1'b0;
      end
      q12      = mul_ff[RECIP_SHIFT +: Q12_W];
      sector   = 4'(rel_ff - REL_W'({q12, 3'b0}) - REL_W'({q12, 2'b0}));
      new_addr = {sector, q12[Q12_W-1:1], q12[0], disk_ff, 1'b0};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(BITMAP_WORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (mode_ff)
               MODE_ALLOC: state_in = ST_SCAN;
               MODE_FREE:  state_in = in_range ? ST_FREE_CHK : ST_IDLE;
               MODE_LOAD:  state_in = widx_ok ? ST_LOAD_CHK : ST_IDLE;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_SCAN: begin
            if (tag_vld_ff && hit_any) begin
               state_in = ST_ENC_MUL;
            end else if (tag_vld_ff && tag_final) begin
               state_in = ST_IDLE;
            end
         end
         ST_ENC_MUL:  state_in = ST_ENC_OUT;
         ST_ENC_OUT:  state_in = ST_IDLE;
         ST_FREE_CHK: state_in = ST_IDLE;
         ST_LOAD_CHK: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // register next values
   always_comb begin
      clr_in        = clr_ff;
      mode_in       = mode_ff;
      daddr_in      = daddr_ff;
      widx_in       = widx_ff;
      wval_in       = wval_ff;
      page_in       = page_ff;
      sw_in         = sw_ff;
      so_in         = so_ff;
      iss_word_in   = iss_word_ff;
      iss_phase_in  = iss_phase_ff;
      iss_done_in   = iss_done_ff;
      tag_word_in   = tag_word_ff;
      tag_phase_in  = tag_phase_ff;
      tag_vld_in    = 1'b0;
      rel_in        = rel_ff;
      disk_in       = disk_ff;
      mul_in        = mul_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_addr_in   = '0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               daddr_in = req_disk_address;
               widx_in  = req_word_index;
               wval_in  = req_word_value;
            end
         end
         ST_DECODE: begin
            page_in      = dec_page;
            sw_in        = start_page[AW+3:4];
            so_in        = start_page[3:0];
            iss_word_in  = start_page[AW+3:4];
            iss_phase_in = 1'b0;
            iss_done_in  = 1'b0;
            case (mode_ff)
               MODE_ALLOC: rsp_strobe_in = 1'b0;
               MODE_FREE:  rsp_strobe_in = !in_range;
               MODE_LOAD:  rsp_strobe_in = !widx_ok;
               default:    rsp_strobe_in = 1'b1;
            endcase
         end
         ST_SCAN: begin
            tag_vld_in   = !iss_done_ff;
            tag_word_in  = iss_word_ff;
            tag_phase_in = iss_phase_ff;
            if (!iss_done_ff) begin
               if (!iss_phase_ff && iss_word_ff == last_word) begin
                  iss_phase_in = 1'b1;
                  iss_word_in  = '0;
               end else if (iss_phase_ff && iss_word_ff == sw_ff) begin
                  iss_done_in = 1'b1;
               end else begin
                  iss_word_in = iss_word_ff + AW'(1);
               end
            end
            if (tag_vld_ff && hit_any) begin
               tag_vld_in = 1'b0;
               page_in    = hit_page;
               count_in   = (count_ff != '0) ? count_ff - COUNT_W'(1) : count_ff;
            end else if (tag_vld_ff && tag_final) begin
               tag_vld_in    = 1'b0;
               rsp_strobe_in = 1'b1;
            end
         end
         ST_ENC_MUL: begin
            rel_in  = rel_comb;
            disk_in = disk_comb;
            mul_in  = MUL_W'(rel_comb) * MUL_W'(RECIP_12);
         end
         ST_ENC_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_found_in  = 1'b1;
            rsp_addr_in   = new_addr;
         end
         ST_FREE_CHK: begin
            if (page_used && count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
            rsp_strobe_in = 1'b1;
         end
         ST_LOAD_CHK: begin
            count_in      = load_count;
            rsp_strobe_in = 1'b1;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
      rsp_free_in = count_in;
   end

   // RAM control and status
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      ram_we    = 1'b0;
      ram_waddr = tag_word_ff;
      ram_wdata = ram_rd_data;
      ram_raddr = iss_word_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = ALL_USED;
         end
         ST_DECODE: begin
            ram_raddr = (mode_ff == MODE_LOAD) ? widx_ff[AW-1:0] : dec_page[AW+3:4];
         end
         ST_SCAN: begin
            ram_we    = tag_vld_ff && hit_any;
            ram_waddr = tag_word_ff;
            ram_wdata = ram_rd_data | (TOP_BIT >> hit_idx);
         end
         ST_FREE_CHK: begin
            ram_we    = page_used;
            ram_waddr = page_ff[AW+3:4];
            ram_wdata = ram_rd_data & ~bit_mask;
         end
         ST_LOAD_CHK: begin
            ram_we    = 1'b1;
            ram_waddr = widx_ff[AW-1:0];
            ram_wdata = wval_ff;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         dd_ff         <= 1'b0;
         count_ff      <= '0;
         iss_done_ff   <= 1'b1;
         tag_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_found_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         if (csr_write_enable) begin
            dd_ff <= csr_write_data;
         end
         count_ff      <= count_in;
         iss_done_ff   <= iss_done_in;
         tag_vld_ff    <= tag_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_found_ff  <= rsp_found_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      daddr_ff     <= daddr_in;
      widx_ff      <= widx_in;
      wval_ff      <= wval_in;
      page_ff      <= page_in;
      sw_ff        <= sw_in;
      so_ff        <= so_in;
      iss_word_ff  <= iss_word_in;
      iss_phase_ff <= iss_phase_in;
      tag_word_ff  <= tag_word_in;
      tag_phase_ff <= tag_phase_in;
      rel_ff       <= rel_in;
      disk_ff      <= disk_in;
      mul_ff       <= mul_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_free_ff  <= rsp_free_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_new_address = rsp_addr_ff;
   assign rsp_pages_left  = rsp_free_ff;

`ifndef ASSERT_OFF
   a_found_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_found |-> rsp_strobe)
      else $error("found without result strobe");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on back-to-back cycles");

   a_hit_encode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && ram_we) |=> (state_ff == ST_ENC_MUL))
      else $error("scan hit did not lead to encode");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_strobe && busy))
      else $error("activity during clearing pass");
`endif

endmodule

>>> test/tb_bitmap_page_allocator.sv
`timescale 1ns / 100ps

module tb_bitmap_page_allocator;
   import bpa_pkg::*;

   localparam int PAGES_PER_DISK = 4872;
   localparam int BITMAP_WORDS   = 1024;
   localparam int CYCLE_LIMIT    = 2500000;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]         mode;
      logic [DADDR_W-1:0] disk_address;
      logic [WIDX_W-1:0]  word_index;
      logic [WORD_W-1:0]  word_value;
      bit                 drain;
   } page_request_type;

   typedef struct {
      logic [DADDR_W-1:0] new_address;
      logic               found;
      logic [COUNT_W-1:0] pages_left;
   } page_reply_type;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               start            = 1'b0;
   logic               busy;
   logic [1:0]         req_mode         = '0;
   logic [DADDR_W-1:0] req_disk_address = '0;
   logic [WIDX_W-1:0]  req_word_index   = '0;
   logic [WORD_W-1:0]  req_word_value   = '0;
   logic               rsp_strobe;
   logic [DADDR_W-1:0] rsp_new_address;
   logic               rsp_found;
   logic [COUNT_W-1:0] rsp_pages_left;
   logic               csr_write_enable = 1'b0;
   logic               csr_write_data   = 1'b0;

   page_request_type  queued_requests[$];
   page_reply_type    predicted_replies[$];
   page_request_type  current_request;
   logic [WORD_W-1:0] page_map [BITMAP_WORDS];
   int unsigned       free_total;
   bit                disk_pair;
   int                sender_idle_pct;
   int                mismatches;
   int                cycle_count;

   bitmap_page_allocator #(
      .PAGES_PER_DISK(PAGES_PER_DISK),
      .BITMAP_WORDS(BITMAP_WORDS)
   ) u_top (.*);

   always #10 clock = ~clock;

   function automatic int unsigned page_limit();
      int unsigned lim;
      lim = disk_pair ? 2 * PAGES_PER_DISK : PAGES_PER_DISK;
      return (lim > BITMAP_WORDS * 16) ? BITMAP_WORDS * 16 : lim;
   endfunction

   function automatic int unsigned addr_to_page(logic [DADDR_W-1:0] a);
      int unsigned p;
      p = int'(a[11:3]) * 24 + int'(a[2]) * 12 + int'(a[15:12]);
      if (a[1])
         p += PAGES_PER_DISK;
      return p;
   endfunction

   function automatic logic [DADDR_W-1:0] page_to_addr(int unsigned p);
      logic [DADDR_W-1:0] a;
      bit                 second;
      second = (p >= PAGES_PER_DISK);
      if (second)
         p -= PAGES_PER_DISK;
      a        = '0;
      a[15:12] = 4'(p % 12);
      a[11:3]  = 9'(p / 24);
      a[2]     = 1'((p / 12) % 2);
      a[1]     = second;
      return a;
   endfunction

   function automatic bit page_used(int unsigned p);
      return page_map[(p >> 4) % BITMAP_WORDS][15 - (p % 16)];
   endfunction

   function automatic int unsigned free_in_word(int unsigned w, logic [WORD_W-1:0] v,
                                                int unsigned lim);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 16; i++)
         if (w * 16 + i < lim && !v[15 - i])
            n++;
      return n;
   endfunction

   function automatic page_reply_type apply_page_request(page_request_type r);
      page_reply_type res;
      int unsigned lim, p, n, old_free, new_free;
      bit          got;
      res.new_address = '0;
      res.found       = 1'b0;
      lim             = page_limit();
      got             = 1'b0;
      case (r.mode)
         MODE_ALLOC: begin
            p = addr_to_page(r.disk_address);
            if (p >= lim)
               p = 0;
            for (n = 0; n < lim && !got; n++) begin
               if (!page_used(p))
                  got = 1'b1;
               else
                  p = (p + 1 == lim) ? 0 : p + 1;
            end
            if (got) begin
               page_map[p >> 4][15 - (p % 16)] = 1'b1;
               if (free_total > 0)
                  free_total--;
               res.new_address = page_to_addr(p);
               res.found       = 1'b1;
            end
         end
         MODE_FREE: begin
            p = addr_to_page(r.disk_address);
            if (p < lim && page_used(p)) begin
               page_map[p >> 4][15 - (p % 16)] = 1'b0;
               if (free_total < COUNT_MAX)
                  free_total++;
            end
         end
         MODE_LOAD: begin
            if (r.word_index < BITMAP_WORDS) begin
               old_free = free_in_word(r.word_index, page_map[r.word_index], lim);
               new_free = free_in_word(r.word_index, r.word_value, lim);
               page_map[r.word_index] = r.word_value;
               if (new_free >= old_free)
                  free_total = (free_total + new_free - old_free > COUNT_MAX) ?
                               COUNT_MAX : free_total + new_free - old_free;
               else
                  free_total = (free_total > old_free - new_free) ?
                               free_total - (old_free - new_free) : 0;
            end
         end
         default: ;
      endcase
      res.pages_left = COUNT_W'(free_total);
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            predicted_replies.push_back(apply_page_request(current_request));
         if (!start || !busy) begin
            if (queued_requests.size() == 0
                || (queued_requests[0].drain && predicted_replies.size() != 0)
                || $urandom_range(99) < sender_idle_pct) begin
               start <= 1'b0;
            end else begin
               current_request = queued_requests.pop_front();
               start            <= 1'b1;
               req_mode         <= current_request.mode;
               req_disk_address <= current_request.disk_address;
               req_word_index   <= current_request.word_index;
               req_word_value   <= current_request.word_value;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      page_reply_type want;
      if (!reset && rsp_strobe) begin
         if (predicted_replies.size() == 0) begin
            $error("result with no request outstanding: new_address %h pages_left %0d",
                   rsp_new_address, rsp_pages_left);
            mismatches++;
         end else begin
            want = predicted_replies.pop_front();
            if (rsp_new_address !== want.new_address) begin
               $error("new_address: expected %h, actual %h", want.new_address, rsp_new_address);
               mismatches++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %b, actual %b", want.found, rsp_found);
               mismatches++;
            end
            if (rsp_pages_left !== want.pages_left) begin
               $error("pages_left: expected %0d, actual %0d", want.pages_left, rsp_pages_left);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void push_request(logic [1:0] m, logic [DADDR_W-1:0] a,
                                        logic [WIDX_W-1:0] idx, logic [WORD_W-1:0] v);
      page_request_type r;
      r.mode         = m;
      r.disk_address = a;
      r.word_index   = idx;
      r.word_value   = v;
      r.drain        = 1'b0;
      queued_requests.push_back(r);
   endfunction

   task automatic wait_idle();
      repeat (8) @(posedge clock);
      while (busy !== 1'b0 || start || queued_requests.size() != 0
             || predicted_replies.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_double(bit v);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      disk_pair = v;
   endtask

   task automatic run_phase(bit dbl, int idle_pct, int count, int drain_at);
      page_request_type r;
      int unsigned   lim, pick;
      set_double(dbl);
      sender_idle_pct = idle_pct;
      lim = page_limit();
      for (int i = 0; i < count; i++) begin
         r.disk_address = DADDR_W'($urandom);
         r.word_index   = WIDX_W'($urandom);
         r.word_value   = WORD_W'($urandom);
         r.drain        = (i == drain_at);
         pick = $urandom_range(99);
         if (pick < 45)
            r.mode = MODE_ALLOC;
         else if (pick < 72)
            r.mode = MODE_FREE;
         else if (pick < 94)
            r.mode = MODE_LOAD;
         else
            r.mode = 2'($urandom);
         if (r.mode != MODE_LOAD && $urandom_range(9) != 0) begin
            r.disk_address    = page_to_addr($urandom_range(lim - 1));
            r.disk_address[0] = 1'($urandom);
         end
         if (r.mode == MODE_LOAD) begin
            if ($urandom_range(4) != 0)
               r.word_index = WIDX_W'($urandom_range((lim - 1) / 16));
            pick = $urandom_range(5);
            if (pick == 0)
               r.word_value = '0;
            else if (pick == 1)
               r.word_value = ALL_USED;
         end
         queued_requests.push_back(r);
      end
   endtask

   initial begin
      foreach (page_map[i])
         page_map[i] = ALL_USED;
      free_total      = 0;
      disk_pair       = 1'b0;
      sender_idle_pct = 0;
      mismatches      = 0;
      cycle_count     = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single disk
      set_double(1'b0);
      push_request(MODE_ALLOC, 16'h0000, 10'd0, 16'h0000);    // bitmap full
      push_request(MODE_LOAD, 16'h0000, 10'd0, 16'h0000);
      push_request(MODE_LOAD, 16'h0000, 10'd1023, 16'h0000);  // past page range
      push_request(MODE_LOAD, 16'h0000, 10'd304, 16'h0000);   // straddles the limit
      push_request(MODE_LOAD, 16'h0000, 10'd400, 16'h0000);   // second disk, not counted
      push_request(MODE_ALLOC, 16'h0000, 10'd0, 16'h0000);
      push_request(MODE_ALLOC, 16'hffff, 10'd0, 16'h0000);    // start out of range
      push_request(MODE_ALLOC, 16'hb654, 10'd0, 16'h0000);    // last page of disk
      push_request(MODE_ALLOC, 16'hb654, 10'd0, 16'h0000);    // wraps to page 0
      push_request(MODE_FREE, 16'hb654, 10'd0, 16'h0000);
      push_request(MODE_FREE, 16'hb654, 10'd0, 16'h0000);     // already free
      push_request(MODE_FREE, 16'hffff, 10'd0, 16'h0000);     // out of range
      push_request(MODE_FREE, 16'h0001, 10'd0, 16'h0000);     // bit 0 ignored
      push_request(MODE_UNUSED, 16'hffff, 10'd1023, 16'hffff);
      push_request(MODE_LOAD, 16'h0000, 10'd0, 16'hffff);

      // two disks: top page, second disk origin, count driven to zero
      set_double(1'b1);
      push_request(MODE_FREE, 16'hb656, 10'd0, 16'h0000);
      push_request(MODE_ALLOC, 16'hb656, 10'd0, 16'h0000);
      push_request(MODE_ALLOC, 16'h0002, 10'd0, 16'h0000);
      push_request(MODE_ALLOC, 16'hffff, 10'd0, 16'h0000);
      for (int i = 0; i < 7; i++)
         push_request(MODE_ALLOC, 16'h0000, 10'd0, 16'h0000);

      run_phase(1'b1, 0, 240, -1);
      run_phase(1'b0, 53, 240, 120);
      run_phase(1'b1, 9, 220, 60);
      run_phase(1'b0, 0, 230, -1);

      wait_idle();
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
